@@ rtl/dam_pkg.sv @@
// Shared types and constants for the dense-graph shortest path block.
package dam_pkg;

  localparam int unsigned DEF_MAX_VERTICES = 32;
  localparam int unsigned DEF_WEIGHT_BITS  = 16;

  localparam int unsigned VTX_W    = 6;
  localparam int unsigned WT_IN_W  = 16;
  localparam int unsigned DIST_W   = 22;
  localparam int unsigned CFG_W    = 7;

  localparam logic [DIST_W-1:0] DIST_MAX  = 22'h3F_FFFF;
  localparam logic [CFG_W-1:0]  CFG_RESET = 7'd32;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_RUN   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_RELAX,
    ST_RELAX_END,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic edge_wr;
    logic run_start;
    logic idx_clr;
    logic scan_begin;
    logic issue;
    logic relax;
    logic visit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic idx_last;
    logic found;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/dijkstra_adjacency_matrix_top.sv @@
// Single-source shortest paths over a dense adjacency matrix.
// Reset (asynchronous, active low) clears control state and sets vertex_count to 32; the edge
// store is then swept clear entry by entry while the input is held not ready.
// Edge write transactions are taken while idle. A run makes up to N+1 min scans and N
// relax passes, then the results leave one at a time, each held until it is taken;
// one transaction is in work at a time.
module dijkstra_adjacency_matrix_top #(
  parameter int unsigned MAX_VERTICES = dam_pkg::DEF_MAX_VERTICES,
  parameter int unsigned WEIGHT_BITS  = dam_pkg::DEF_WEIGHT_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dam_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [dam_pkg::VTX_W-1:0]   from_vertex_i,
  input  logic [dam_pkg::VTX_W-1:0]   to_vertex_i,
  input  logic [dam_pkg::WT_IN_W-1:0] edge_weight_i,
  input  logic                        edge_present_i,
  input  logic [dam_pkg::VTX_W-1:0]   source_vertex_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dam_pkg::VTX_W-1:0]   vertex_index_o,
  output logic [dam_pkg::DIST_W-1:0]  distance_o,
  output logic                        reachable_o,
  output logic [dam_pkg::VTX_W-1:0]   predecessor_o,
  output logic                        last_result_o
);

  dam_pkg::cmd_t cmd;
  dam_pkg::sts_t sts;

  dam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dam_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .from_vertex_i   (from_vertex_i),
    .to_vertex_i     (to_vertex_i),
    .edge_weight_i   (edge_weight_i),
    .edge_present_i  (edge_present_i),
    .source_vertex_i (source_vertex_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .vertex_index_o  (vertex_index_o),
    .distance_o      (distance_o),
    .reachable_o     (reachable_o),
    .predecessor_o   (predecessor_o),
    .last_result_o   (last_result_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

@@ rtl/dam_ctrl.sv @@
// Sequencer for edge-store clearing, search rounds and result emission.
module dam_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          action_i,
  output logic          in_ready_o,
  input  dam_pkg::sts_t sts_i,
  output dam_pkg::cmd_t cmd_o
);

  dam_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dam_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dam_pkg::ST_CLEAR: begin
        if (sts_i.clr_done) state_d = dam_pkg::ST_IDLE;
      end
      dam_pkg::ST_IDLE: begin
        if (in_valid_i && action_i == dam_pkg::ACT_RUN) state_d = dam_pkg::ST_SCAN;
      end
      dam_pkg::ST_SCAN: begin
        if (sts_i.idx_last) state_d = dam_pkg::ST_SCAN_END;
      end
      dam_pkg::ST_SCAN_END: begin
        state_d = dam_pkg::ST_DECIDE;
      end
      dam_pkg::ST_DECIDE: begin
        state_d = sts_i.found ? dam_pkg::ST_RELAX : dam_pkg::ST_EMIT_RD;
      end
      dam_pkg::ST_RELAX: begin
        if (sts_i.idx_last) state_d = dam_pkg::ST_RELAX_END;
      end
      dam_pkg::ST_RELAX_END: begin
        state_d = dam_pkg::ST_SCAN;
      end
      dam_pkg::ST_EMIT_RD: begin
        state_d = dam_pkg::ST_EMIT_LD;
      end
      dam_pkg::ST_EMIT_LD: begin
        if (sts_i.out_free) state_d = sts_i.idx_last ? dam_pkg::ST_IDLE : dam_pkg::ST_EMIT_RD;
      end
      default: state_d = dam_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dam_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      dam_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == dam_pkg::ACT_WRITE) begin
            cmd_o.edge_wr = 1'b1;
          end else begin
            cmd_o.run_start  = 1'b1;
            cmd_o.idx_clr    = 1'b1;
            cmd_o.scan_begin = 1'b1;
          end
        end
      end
      dam_pkg::ST_SCAN: begin
        cmd_o.issue = 1'b1;
      end
      dam_pkg::ST_SCAN_END: begin
      end
      dam_pkg::ST_DECIDE: begin
        cmd_o.idx_clr = 1'b1;
        cmd_o.visit   = sts_i.found;
      end
      dam_pkg::ST_RELAX: begin
        cmd_o.issue = 1'b1;
        cmd_o.relax = 1'b1;
      end
      dam_pkg::ST_RELAX_END: begin
        cmd_o.idx_clr    = 1'b1;
        cmd_o.scan_begin = 1'b1;
      end
      dam_pkg::ST_EMIT_RD: begin
      end
      dam_pkg::ST_EMIT_LD: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over an untaken result");

  a_run_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == dam_pkg::ACT_RUN) |=> state_q == dam_pkg::ST_SCAN)
    else $error("run transaction did not start a scan");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && sts_i.idx_last) |=> in_ready_o)
    else $error("block not ready after final result");

endmodule

@@ rtl/dam_datapath.sv @@
// Edge store, distance/predecessor store, min scan and relaxation datapath.
module dam_datapath #(
  parameter int unsigned MAX_VERTICES = dam_pkg::DEF_MAX_VERTICES,
  parameter int unsigned WEIGHT_BITS  = dam_pkg::DEF_WEIGHT_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dam_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [dam_pkg::VTX_W-1:0]   from_vertex_i,
  input  logic [dam_pkg::VTX_W-1:0]   to_vertex_i,
  input  logic [dam_pkg::WT_IN_W-1:0] edge_weight_i,
  input  logic                        edge_present_i,
  input  logic [dam_pkg::VTX_W-1:0]   source_vertex_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [dam_pkg::VTX_W-1:0]   vertex_index_o,
  output logic [dam_pkg::DIST_W-1:0]  distance_o,
  output logic                        reachable_o,
  output logic [dam_pkg::VTX_W-1:0]   predecessor_o,
  output logic                        last_result_o,
  input  dam_pkg::cmd_t               cmd_i,
  output dam_pkg::sts_t               sts_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned AW = 2 * VW;
  localparam int unsigned EW = WEIGHT_BITS + 1;
  localparam int unsigned DW = dam_pkg::DIST_W + VW;
  localparam int unsigned SW = ((WEIGHT_BITS > dam_pkg::DIST_W) ? WEIGHT_BITS : dam_pkg::DIST_W) + 1;
  localparam int unsigned CW = dam_pkg::CFG_W;

  logic [EW-1:0] edge_mem [0:(1<<AW)-1];
  logic [DW-1:0] dp_mem   [0:MAX_VERTICES-1];

  logic [CW-1:0]           vcount_q;
  logic [AW-1:0]           clr_q;
  logic [VW-1:0]           idx_q, idx_d;
  logic [VW-1:0]           last_q;
  logic [VW-1:0]           u_q;
  logic [dam_pkg::DIST_W-1:0] best_q;
  logic                    found_q;
  logic [MAX_VERTICES-1:0] visited_q, dvalid_q;
  logic                    p_valid_q, p_relax_q;
  logic [VW-1:0]           p_idx_q;
  logic [EW-1:0]           edge_rd_q;
  logic [DW-1:0]           dp_rd_q;

  logic                    out_valid_q;
  logic [dam_pkg::VTX_W-1:0]  out_idx_q, out_pred_q;
  logic [dam_pkg::DIST_W-1:0] out_dist_q;
  logic                    out_reach_q, out_last_q;

  logic [VW-1:0]           last_run;
  logic                    src_ok, wr_ok;
  logic [VW-1:0]           src_idx;
  logic [MAX_VERTICES-1:0] src_hot;
  logic [31:0]             wt_ext;
  logic [WEIGHT_BITS-1:0]  wt_in, wt_rd;
  logic [dam_pkg::DIST_W-1:0] dist_cur, dist_sat;
  logic [SW-1:0]           sum;
  logic                    cand, relax_we, idx_last;

  // clamp vertex count to 1..MAX_VERTICES, kept as last index
  always_comb begin
    if (vcount_q == '0) begin
      last_run = '0;
    end else if (vcount_q > CW'(MAX_VERTICES)) begin
      last_run = VW'(MAX_VERTICES - 1);
    end else begin
      last_run = VW'(vcount_q - CW'(1));
    end
  end

  assign src_idx = source_vertex_i[VW-1:0];
  assign src_ok  = CW'(source_vertex_i) <= CW'(last_run);
  assign wr_ok   = (CW'(from_vertex_i) < CW'(MAX_VERTICES)) &&
                   (CW'(to_vertex_i) < CW'(MAX_VERTICES));
  assign wt_ext  = 32'(edge_weight_i);
  assign wt_in   = wt_ext[WEIGHT_BITS-1:0];

  always_comb begin
    src_hot          = '0;
    src_hot[src_idx] = src_ok;
  end

  assign wt_rd    = edge_rd_q[WEIGHT_BITS-1:0];
  assign dist_cur = dp_rd_q[DW-1:VW];
  assign sum      = SW'(best_q) + SW'(wt_rd);
  assign dist_sat = (sum > SW'(dam_pkg::DIST_MAX)) ? dam_pkg::DIST_MAX
                                                   : sum[dam_pkg::DIST_W-1:0];

  assign cand     = p_valid_q && !p_relax_q && !visited_q[p_idx_q] && dvalid_q[p_idx_q] &&
                    (!found_q || dist_cur < best_q);
  assign relax_we = p_valid_q && p_relax_q && edge_rd_q[EW-1] && !visited_q[p_idx_q] &&
                    (!dvalid_q[p_idx_q] || dist_sat < dist_cur);

  assign idx_last = idx_q == last_q;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if ((cmd_i.issue || cmd_i.out_load) && !idx_last) begin
      idx_d = idx_q + VW'(1);
    end
  end

  // edge store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      edge_mem[clr_q] <= '0;
    end else if (cmd_i.edge_wr && wr_ok) begin
      edge_mem[{from_vertex_i[VW-1:0], to_vertex_i[VW-1:0]}] <= {edge_present_i, wt_in};
    end
    edge_rd_q <= edge_mem[{u_q, idx_q}];
  end

  // distance and predecessor store
  always_ff @(posedge clk_i) begin
    if (cmd_i.run_start && src_ok) begin
      dp_mem[src_idx] <= {{dam_pkg::DIST_W{1'b0}}, src_idx};
    end else if (relax_we) begin
      dp_mem[p_idx_q] <= {dist_sat, u_q};
    end
    dp_rd_q <= dp_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= dam_pkg::CFG_RESET;
      clr_q       <= '0;
      idx_q       <= '0;
      last_q      <= '0;
      u_q         <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      visited_q   <= '0;
      dvalid_q    <= '0;
      p_valid_q   <= 1'b0;
      p_relax_q   <= 1'b0;
      p_idx_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (cmd_i.clr_en) clr_q <= clr_q + AW'(1);
      idx_q     <= idx_d;
      p_valid_q <= cmd_i.issue;
      p_relax_q <= cmd_i.relax;
      p_idx_q   <= idx_q;
      if (cmd_i.run_start) begin
        last_q    <= last_run;
        visited_q <= '0;
        dvalid_q  <= src_hot;
      end else if (relax_we) begin
        dvalid_q[p_idx_q] <= 1'b1;
      end
      if (cmd_i.visit) visited_q[u_q] <= 1'b1;
      if (cmd_i.scan_begin) found_q <= 1'b0;
      if (cand) begin
        found_q <= 1'b1;
        u_q     <= p_idx_q;
        best_q  <= dist_cur;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q   <= dam_pkg::VTX_W'(idx_q);
      out_reach_q <= dvalid_q[idx_q];
      out_dist_q  <= dvalid_q[idx_q] ? dist_cur : '0;
      out_pred_q  <= dvalid_q[idx_q] ? dam_pkg::VTX_W'(dp_rd_q[VW-1:0])
                                     : dam_pkg::VTX_W'(idx_q);
      out_last_q  <= idx_last;
    end
  end

  assign sts_o.clr_done = &clr_q;
  assign sts_o.idx_last = idx_last;
  assign sts_o.found    = found_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = out_idx_q;
  assign distance_o     = out_dist_q;
  assign reachable_o    = out_reach_q;
  assign predecessor_o  = out_pred_q;
  assign last_result_o  = out_last_q;

  a_visit_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (visited_q & ~dvalid_q) == '0)
    else $error("visited vertex without a finite distance");

  a_found_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> dvalid_q[u_q])
    else $error("picked vertex has no finite distance");

endmodule
